@@ hw/rtl/stuffed_bit_packer_assert.svh @@
// Assertion macros for the stuffed bit packer.
`ifndef STUFFED_BIT_PACKER_ASSERT_SVH
`define STUFFED_BIT_PACKER_ASSERT_SVH

`ifndef SYNTH
`define SPB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define SPB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SPB_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg)
`endif

`endif

@@ hw/rtl/spb_pkg.sv @@
// Shared types and constants of the stuffed bit packer.
`timescale 1ns / 1ps

package spb_pkg;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;
	localparam logic [7:0] STUFF_BYTE  = 8'h00;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic pop;
		logic sel_stuff;
	} spb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] load_bytes;
		logic       top_ff;
		logic       one_left;
	} spb_stat_t;

endpackage

@@ hw/rtl/spb_in_if.sv @@
// Input request channel of the stuffed bit packer.
`timescale 1ns / 1ps

interface spb_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] code_value;
	logic [4:0]  bit_count;

	modport source (output valid, output command, output code_value, output bit_count,
		input ready);
	modport sink (input valid, input command, input code_value, input bit_count,
		output ready);
endinterface

@@ hw/rtl/spb_out_if.sv @@
// Output byte channel of the stuffed bit packer.
`timescale 1ns / 1ps

interface spb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ hw/rtl/spb_dpath.sv @@
// Datapath: bit accumulator, byte shift register and byte counter.
`timescale 1ns / 1ps

module spb_dpath #(
	parameter int MAX_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                command,
	input  logic [15:0]         code_value,
	input  logic [4:0]          bit_count,
	input  spb_pkg::spb_cmd_t   cmd,
	output spb_pkg::spb_stat_t  stat,
	output logic [7:0]          out_byte
);

	localparam int CapInt = (MAX_BITS < 16) ? MAX_BITS : 16;
	localparam logic [4:0] CapBits = 5'(CapInt);

	// Pending bits are kept left-aligned in acc_q.
	logic [7:0]  acc_q;
	logic [2:0]  pend_q;
	logic [23:0] sh_q;
	logic [1:0]  cnt_q;

	logic [4:0]  n_eff;
	logic [15:0] val_left;
	logic [23:0] wr_word;
	logic [4:0]  total;
	logic [23:0] wr_rest;
	logic [7:0]  fl_byte;
	logic [23:0] load_word;
	logic [1:0]  load_bytes;
	logic [7:0]  acc_next;
	logic [2:0]  pend_next;

	always_comb begin
		n_eff    = (bit_count > CapBits) ? CapBits : bit_count;
		// Shifting the code to the top drops the unused high bits.
		val_left = code_value << (5'd16 - n_eff);
		wr_word  = {acc_q, 16'h0000} | ({val_left, 8'h00} >> pend_q);
		total    = {2'b00, pend_q} + n_eff;
		wr_rest  = wr_word << {total[4:3], 3'b000};
		fl_byte  = acc_q | (8'hFF >> pend_q);
		if (command == spb_pkg::CMD_FLUSH) begin
			load_word  = {fl_byte, 16'h0000};
			load_bytes = (pend_q != 3'd0) ? 2'd1 : 2'd0;
			acc_next   = 8'h00;
			pend_next  = 3'd0;
		end else begin
			load_word  = wr_word;
			load_bytes = total[4:3];
			acc_next   = wr_rest[23:16];
			pend_next  = total[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 8'h00;
			pend_q <= 3'd0;
			cnt_q  <= 2'd0;
		end else if (cmd.load) begin
			acc_q  <= acc_next;
			pend_q <= pend_next;
			cnt_q  <= load_bytes;
		end else if (cmd.pop) begin
			cnt_q  <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q <= load_word;
		end else if (cmd.pop) begin
			sh_q <= {sh_q[15:0], 8'h00};
		end
	end

	assign stat.load_bytes = load_bytes;
	assign stat.top_ff     = (sh_q[23:16] == spb_pkg::MARKER_BYTE);
	assign stat.one_left   = (cnt_q == 2'd1);
	assign out_byte        = cmd.sel_stuff ? spb_pkg::STUFF_BYTE : sh_q[23:16];

endmodule

@@ hw/rtl/spb_ctrl.sv @@
// Controller: accepts requests and sequences data and stuffing bytes.
`timescale 1ns / 1ps

`include "stuffed_bit_packer_assert.svh"

module spb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               last_of_run,
	input  spb_pkg::spb_stat_t stat,
	output spb_pkg::spb_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_STUFF
	} state_t;

	state_t state_q;
	logic   out_fire;

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = (state_q != ST_IDLE);
	assign out_fire      = out_valid && out_ready;
	assign cmd.load      = in_valid && in_ready;
	assign cmd.sel_stuff = (state_q == ST_STUFF);
	// A data byte of 0xFF stays in place until its stuffing byte has gone out.
	assign cmd.pop       = out_fire && ((state_q == ST_STUFF) || !stat.top_ff);
	assign last_of_run   = stat.one_left &&
		((state_q == ST_STUFF) || ((state_q == ST_EMIT) && !stat.top_ff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && (stat.load_bytes != 2'd0)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_fire) begin
						if (stat.top_ff) begin
							state_q <= ST_STUFF;
						end else if (stat.one_left) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STUFF: begin
					if (out_fire) begin
						state_q <= stat.one_left ? ST_IDLE : ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SPB_ASSERT_NEXT(a_ff_then_stuff, clk, arst_n, (state_q == ST_EMIT) && out_fire && stat.top_ff, state_q == ST_STUFF, "0xFF byte not followed by stuffing")
	`SPB_ASSERT_NEXT(a_last_ends_run, clk, arst_n, out_fire && last_of_run, state_q == ST_IDLE, "run did not end after last byte")
	`SPB_ASSERT(a_stuff_after_ff, clk, arst_n, (state_q == ST_STUFF) |-> stat.top_ff, "stuffing without 0xFF byte")

endmodule

@@ hw/rtl/stuffed_bit_packer.sv @@
// Top level of the stuffed bit packer.
// A request is taken while the controller is idle; its first byte, if it causes any, is offered the next cycle.
// A request causes 0 to 4 output bytes, its stuffing bytes included.
// A new request is taken only once every byte of the previous one has been taken.
// The controller serializes the bytes of one request over the byte-wide output port.
// Reset (arst_n low, asynchronous) empties the accumulator and drops any pending bytes.
`timescale 1ns / 1ps

module stuffed_bit_packer #(
	parameter int MAX_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	spb_in_if.sink   in_ch,
	spb_out_if.source out_ch
);

	spb_pkg::spb_cmd_t  cmd;
	spb_pkg::spb_stat_t stat;

	spb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.last_of_run (out_ch.last_of_run),
		.stat        (stat),
		.cmd         (cmd)
	);

	spb_dpath #(
		.MAX_BITS (MAX_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (in_ch.command),
		.code_value (in_ch.code_value),
		.bit_count  (in_ch.bit_count),
		.cmd        (cmd),
		.stat       (stat),
		.out_byte   (out_ch.out_byte)
	);

endmodule
